// ===== rtl/sdhs_pkg.sv =====
// Shared types and constants of the spring-damper heading smoother.
`default_nettype none

package sdhs_pkg;

   // Field and register widths
   localparam int HEADING_WIDTH   = 17;
   localparam int VELOCITY_WIDTH  = 24;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   // Angle constants in 1/256 degree units
   localparam logic [HEADING_WIDTH-1:0] FULL_TURN   = 17'd92160;
   localparam logic signed [17:0]       FULL_TURN_S = 18'sd92160;
   localparam logic signed [17:0]       HALF_TURN_S = 18'sd46080;

   // Velocity saturation limits
   localparam logic signed [VELOCITY_WIDTH-1:0] VEL_MAX = 24'sh7FFFFF;
   localparam logic signed [VELOCITY_WIDTH-1:0] VEL_MIN = 24'sh800000;

   // A full turn is 45 * 2^11: the position is wrapped by splitting off the low
   // 11 bits and reducing the rest modulo 45 through a reciprocal multiply.
   localparam logic [13:0]        WRAP_DIV    = 14'd45;
   localparam logic [13:0]        WRAP_RECIP  = 14'd11650;
   localparam logic signed [14:0] WRAP_OFFSET = 15'sd4140;

   // Register reset values
   localparam logic [CSR_DATA_WIDTH-1:0] SPRING_RESET  = 16'd15360;
   localparam logic [CSR_DATA_WIDTH-1:0] DAMPING_RESET = 16'd1536;
   localparam logic [CSR_DATA_WIDTH-1:0] STEP_RESET    = 16'd1092;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SPRING_PER_MASS  = 2'd0,
      CSR_DAMPING_PER_MASS = 2'd1,
      CSR_TIME_STEP        = 2'd2
   } csr_index_type;

   // Commands from the controller to the datapath, one per step
   typedef struct packed {
      logic load_target;
      logic calc_diff;
      logic mul_accel;
      logic sum_accel;
      logic mul_vel;
      logic calc_vstep;
      logic update_vel;
      logic mul_pos;
      logic sum_pos;
      logic wrap_split;
      logic wrap_quot;
      logic wrap_rem;
      logic load_out;
   } sdhs_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/sdhs_ctrl.sv =====
// Controller state machine that sequences one update tick through the datapath.
`default_nettype none

module sdhs_ctrl import sdhs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sdhs_cmd_type cmd
);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'h0001,
      ST_DIFF   = 13'h0002,
      ST_MUL_A  = 13'h0004,
      ST_ACCEL  = 13'h0008,
      ST_MUL_B  = 13'h0010,
      ST_VSTEP  = 13'h0020,
      ST_VSAT   = 13'h0040,
      ST_MUL_P  = 13'h0080,
      ST_PSUM   = 13'h0100,
      ST_WRAP_Q = 13'h0200,
      ST_WRAP_M = 13'h0400,
      ST_WRAP_R = 13'h0800,
      ST_OUT    = 13'h1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Commands follow the current step
   always_comb begin
      cmd             = '0;
      cmd.load_target = accept;
      cmd.calc_diff   = (state_ff == ST_DIFF);
      cmd.mul_accel   = (state_ff == ST_MUL_A);
      cmd.sum_accel   = (state_ff == ST_ACCEL);
      cmd.mul_vel     = (state_ff == ST_MUL_B);
      cmd.calc_vstep  = (state_ff == ST_VSTEP);
      cmd.update_vel  = (state_ff == ST_VSAT);
      cmd.mul_pos     = (state_ff == ST_MUL_P);
      cmd.sum_pos     = (state_ff == ST_PSUM);
      cmd.wrap_split  = (state_ff == ST_WRAP_Q);
      cmd.wrap_quot   = (state_ff == ST_WRAP_M);
      cmd.wrap_rem    = (state_ff == ST_WRAP_R);
      cmd.load_out    = (state_ff == ST_OUT) && out_free;
   end

   // Next state: a fixed walk through the steps, holding at the end until the
   // output register is free.
   always_comb begin
      case (state_ff)
         ST_IDLE:   state_in = accept ? ST_DIFF : ST_IDLE;
         ST_DIFF:   state_in = ST_MUL_A;
         ST_MUL_A:  state_in = ST_ACCEL;
         ST_ACCEL:  state_in = ST_MUL_B;
         ST_MUL_B:  state_in = ST_VSTEP;
         ST_VSTEP:  state_in = ST_VSAT;
         ST_VSAT:   state_in = ST_MUL_P;
         ST_MUL_P:  state_in = ST_PSUM;
         ST_PSUM:   state_in = ST_WRAP_Q;
         ST_WRAP_Q: state_in = ST_WRAP_M;
         ST_WRAP_M: state_in = ST_WRAP_R;
         ST_WRAP_R: state_in = ST_OUT;
         ST_OUT:    state_in = out_free ? ST_IDLE : ST_OUT;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Result valid is set on load and cleared by a transfer
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sdhs_datapath.sv =====
// Datapath: configuration registers, needle state and the fixed-point update steps.
`default_nettype none

module sdhs_datapath import sdhs_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  sdhs_cmd_type               cmd,
   input  logic [HEADING_WIDTH-1:0]   req_target_heading,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output logic [HEADING_WIDTH-1:0]   rsp_smoothed_heading
);

   localparam logic [40:0]        VelRound = 41'd8388608;
   localparam logic signed [40:0] PosRound = 41'sd32768;

   // Configuration registers
   logic [CSR_DATA_WIDTH-1:0] spring_ff;
   logic [CSR_DATA_WIDTH-1:0] damping_ff;
   logic [CSR_DATA_WIDTH-1:0] step_ff;

   // Needle state
   logic [HEADING_WIDTH-1:0]         pos_ff, pos_in;
   logic signed [VELOCITY_WIDTH-1:0] vel_ff, vel_in;

   // Intermediate registers
   logic [HEADING_WIDTH-1:0] target_ff, target_in;
   logic signed [17:0]       diff_raw, diff_fold;
   logic signed [16:0]       diff_ff, diff_in;
   logic signed [33:0]       kd_ff, kd_in;
   logic signed [40:0]       cv_ff, cv_in;
   logic signed [40:0]       accel_ff, accel_in;
   logic [39:0]              plo_ff, plo_in;
   logic signed [33:0]       phi_ff, phi_in;
   logic [40:0]              vel_rnd;
   logic signed [33:0]       vstep_ff, vstep_in;
   logic signed [34:0]       vsum;
   logic signed [40:0]       pprod_ff, pprod_in;
   logic signed [40:0]       pos_rnd;
   logic signed [24:0]       pstep;
   logic signed [25:0]       psum_ff, psum_in;
   logic signed [14:0]       quo_sum;
   logic [13:0]              quo_ff, quo_in;
   logic [10:0]              low_ff, low_in;
   logic [27:0]              recip_prod;
   logic [7:0]               qest_ff, qest_in;
   logic [13:0]              back_prod, rem_raw, rem;
   logic [HEADING_WIDTH-1:0] out_ff;

   // Configuration writes; an unknown index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         spring_ff  <= SPRING_RESET;
         damping_ff <= DAMPING_RESET;
         step_ff    <= STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SPRING_PER_MASS:  spring_ff  <= csr_write_data;
            CSR_DAMPING_PER_MASS: damping_ff <= csr_write_data;
            CSR_TIME_STEP:        step_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Target is brought into one turn as it is captured
   assign target_in = (req_target_heading >= FULL_TURN) ? req_target_heading - FULL_TURN
                                                        : req_target_heading;

   // Shortest signed difference, folded into the half-turn range
   assign diff_raw = $signed({1'b0, target_ff}) - $signed({1'b0, pos_ff});
   always_comb begin
      if (diff_raw > HALF_TURN_S) begin
         diff_fold = diff_raw - FULL_TURN_S;
      end else if (diff_raw < -HALF_TURN_S) begin
         diff_fold = diff_raw + FULL_TURN_S;
      end else begin
         diff_fold = diff_raw;
      end
   end
   assign diff_in = $signed(diff_fold[16:0]);

   // Spring and damping terms, then acceleration
   assign kd_in    = $signed({1'b0, spring_ff}) * diff_ff;
   assign cv_in    = $signed({1'b0, damping_ff}) * vel_ff;
   assign accel_in = 41'(kd_ff) - cv_ff;

   // Acceleration times time step, split into low and high partial products
   assign plo_in = accel_ff[23:0] * step_ff;
   assign phi_in = $signed(accel_ff[40:24]) * $signed({1'b0, step_ff});

   // Velocity step rounded at bit 24: the low product adds its rounded part above bit 24
   assign vel_rnd  = {1'b0, plo_ff} + VelRound;
   assign vstep_in = phi_ff + $signed({17'd0, vel_rnd[40:24]});

   // Saturating velocity update
   assign vsum = 35'(vel_ff) + 35'(vstep_ff);
   always_comb begin
      if (vsum > 35'(VEL_MAX)) begin
         vel_in = VEL_MAX;
      end else if (vsum < 35'(VEL_MIN)) begin
         vel_in = VEL_MIN;
      end else begin
         vel_in = $signed(vsum[23:0]);
      end
   end

   // Position step rounded at bit 16, then added to the old position
   assign pprod_in = vel_ff * $signed({1'b0, step_ff});
   assign pos_rnd  = pprod_ff + PosRound;
   assign pstep    = $signed(pos_rnd[40:16]);
   assign psum_in  = 26'($signed({1'b0, pos_ff})) + 26'(pstep);

   // Wrap: split off the low 11 bits and offset the rest to a positive value
   assign quo_sum = $signed(psum_ff[25:11]) + WRAP_OFFSET;
   assign quo_in  = quo_sum[13:0];
   assign low_in  = psum_ff[10:0];

   // Quotient by 45 through the reciprocal; it may come out one short
   assign recip_prod = 28'(quo_ff) * 28'(WRAP_RECIP);
   assign qest_in    = recip_prod[26:19];

   // Remainder with one corrective subtract
   assign back_prod = 14'(qest_ff) * WRAP_DIV;
   assign rem_raw   = quo_ff - back_prod;
   assign rem       = (rem_raw >= WRAP_DIV) ? rem_raw - WRAP_DIV : rem_raw;
   assign pos_in    = {rem[5:0], low_ff};

   // Needle state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         vel_ff <= '0;
      end else begin
         if (cmd.update_vel) begin
            vel_ff <= vel_in;
         end
         if (cmd.wrap_rem) begin
            pos_ff <= pos_in;
         end
      end
   end

   // Step registers
   always_ff @(posedge clock) begin
      if (cmd.load_target) begin
         target_ff <= target_in;
      end
      if (cmd.calc_diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.mul_accel) begin
         kd_ff <= kd_in;
         cv_ff <= cv_in;
      end
      if (cmd.sum_accel) begin
         accel_ff <= accel_in;
      end
      if (cmd.mul_vel) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (cmd.calc_vstep) begin
         vstep_ff <= vstep_in;
      end
      if (cmd.mul_pos) begin
         pprod_ff <= pprod_in;
      end
      if (cmd.sum_pos) begin
         psum_ff <= psum_in;
      end
      if (cmd.wrap_split) begin
         quo_ff <= quo_in;
         low_ff <= low_in;
      end
      if (cmd.wrap_quot) begin
         qest_ff <= qest_in;
      end
      if (cmd.load_out) begin
         out_ff <= pos_ff;
      end
   end

   assign rsp_smoothed_heading = out_ff;

endmodule

`default_nettype wire

// ===== rtl/spring_damper_heading_smoother.sv =====
// Top level of the spring-damper heading smoother.
//
// Usage: each tick a target heading (1/256 degree units) is transferred on the
// req_ channel; the block moves its simulated needle one damped-spring Euler
// step toward it and returns the new needle heading on the rsp_ channel.
// The csr_ port writes spring_per_mass (index 0), damping_per_mass (index 1)
// and time_step (index 2) at any clock edge with csr_write_enable high; write
// it only while no tick is in progress.
// A request is taken only while the controller is idle, so a new tick cannot
// start before the last one is through; the controller walks the chain of
// dependent multiplies, adds and the modulo-a-turn reduction one step per
// cycle through the datapath, holding at the end while the output is full.
// Reset (synchronous, active high) restores the register defaults, puts the
// needle at zero degrees with zero velocity and empties the output register.
// A stalled receiver leaves the result in the output register; a new request
// is still transferred, and its result waits in the last step until the
// previous one has been taken.
`default_nettype none

module spring_damper_heading_smoother import sdhs_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [HEADING_WIDTH-1:0]   req_target_heading,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [HEADING_WIDTH-1:0]   rsp_smoothed_heading,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   sdhs_cmd_type cmd;

   // Step sequencer
   sdhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Arithmetic and state
   sdhs_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_target_heading   (req_target_heading),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_smoothed_heading (rsp_smoothed_heading)
   );

endmodule

`default_nettype wire

// ===== rtl/sdhs_checker.sv =====
// Port-level checker for the heading smoother, bound to the top level.
`default_nettype none

module sdhs_assertions import sdhs_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [HEADING_WIDTH-1:0] rsp_smoothed_heading
);

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smoothed_heading))
      else $error("result changed or dropped while stalled");

   // Every heading shown lies within one turn
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_smoothed_heading < FULL_TURN)
      else $error("smoothed heading outside one turn");

   // After a request transfer the block is busy and not ready for another request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken while a tick was in progress");

   // A fresh result appears only as the block returns to accepting requests
   a_done_ready: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while the block is still busy");

endmodule

bind spring_damper_heading_smoother sdhs_assertions u_checker (.*);

`default_nettype wire

// ===== verif/sdhs_checker.sv =====
// Checker for the spring-damper heading smoother: needle predictor and response comparison.
`default_nettype none

module sdhs_checker import sdhs_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [HEADING_WIDTH-1:0]   req_target_heading,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [HEADING_WIDTH-1:0]   rsp_smoothed_heading,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                         error_count,
   output int                         pending_count,
   output logic [HEADING_WIDTH-1:0]   needle_heading
);
   timeunit 1ns;
   timeprecision 1ps;

   // Rounding offsets for the two Euler steps (half of the dropped weight)
   localparam longint VEL_STEP_HALF = 64'sh80_0000;
   localparam longint POS_STEP_HALF = 64'sh8000;

   // Shadow copies of the gain registers and the needle state
   logic [CSR_DATA_WIDTH-1:0]         spring_gain;
   logic [CSR_DATA_WIDTH-1:0]         damping_gain;
   logic [CSR_DATA_WIDTH-1:0]         step_size;
   logic [HEADING_WIDTH-1:0]          needle_pos;
   logic signed [VELOCITY_WIDTH-1:0]  needle_vel;

   // Headings predicted for requests whose responses have not yet arrived
   logic [HEADING_WIDTH-1:0] expected_headings[$];
   int                       response_number;

   assign needle_heading = needle_pos;

   // Reduce any angle into one full turn, [0, FULL_TURN).
   function automatic longint wrap_to_turn(input longint angle);
      longint r;
      r = angle % longint'(FULL_TURN);
      if (r < 0) begin
         r += longint'(FULL_TURN);
      end
      return r;
   endfunction

   // Move the shadow needle one damped-spring tick toward the target and return its heading.
   function automatic logic [HEADING_WIDTH-1:0] advance_needle(
      input logic [HEADING_WIDTH-1:0] target
   );
      longint aim;
      longint diff;
      longint accel;
      longint vel;
      longint pos;
      aim  = wrap_to_turn(longint'(target));
      diff = aim - longint'(needle_pos);
      // Shortest way round; an exact half turn is left as it is.
      if (diff > longint'(HALF_TURN_S)) begin
         diff -= longint'(FULL_TURN_S);
      end else if (diff < -longint'(HALF_TURN_S)) begin
         diff += longint'(FULL_TURN_S);
      end
      accel = longint'(spring_gain) * diff - longint'(damping_gain) * longint'(needle_vel);
      vel   = longint'(needle_vel)
            + ((accel * longint'(step_size) + VEL_STEP_HALF) >>> 24);
      if (vel > longint'(VEL_MAX)) begin
         vel = longint'(VEL_MAX);
      end else if (vel < longint'(VEL_MIN)) begin
         vel = longint'(VEL_MIN);
      end
      needle_vel = VELOCITY_WIDTH'(vel);
      pos        = longint'(needle_pos) + ((vel * longint'(step_size) + POS_STEP_HALF) >>> 16);
      needle_pos = HEADING_WIDTH'(wrap_to_turn(pos));
      return needle_pos;
   endfunction

   // Follow register writes and request transfers, and compare each response transfer.
   always @(posedge clock) begin
      logic [HEADING_WIDTH-1:0] oldest;
      if (reset) begin
         spring_gain  = SPRING_RESET;
         damping_gain = DAMPING_RESET;
         step_size    = STEP_RESET;
         needle_pos   = '0;
         needle_vel   = '0;
         expected_headings.delete();
         response_number = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SPRING_PER_MASS:  spring_gain  = csr_write_data;
               CSR_DAMPING_PER_MASS: damping_gain = csr_write_data;
               CSR_TIME_STEP:        step_size    = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_headings.push_back(advance_needle(req_target_heading));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_headings.size() == 0) begin
               if (error_count < 10) begin
                  $display("response %0d: heading %0d arrived with no request outstanding",
                           response_number, rsp_smoothed_heading);
               end
               error_count++;
            end else begin
               oldest = expected_headings.pop_front();
               if (rsp_smoothed_heading !== oldest) begin
                  if (error_count < 10) begin
                     $display("response %0d: smoothed_heading expected %0d, got %0d",
                              response_number, oldest, rsp_smoothed_heading);
                  end
                  error_count++;
               end
            end
            response_number++;
         end
      end
      pending_count = expected_headings.size();
   end

endmodule

`default_nettype wire

// ===== verif/tb_spring_damper_heading_smoother.sv =====
// Testbench top for the spring-damper heading smoother: clock, reset, stimulus and verdict.
`default_nettype none

module tb_spring_damper_heading_smoother import sdhs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HIGH_NS     = 6;
   localparam int CLOCK_LOW_NS      = 6;
   localparam int PHASE_COUNT       = 6;
   localparam int CHUNKS_PER_PHASE  = 5;
   localparam int ITEMS_PER_CHUNK   = 50;
   localparam int HOLD_OFF_CYCLES   = 300;
   localparam int SETTLE_CYCLES     = 16;
   localparam int DRAIN_LIMIT       = 5000;
   localparam int RUN_LIMIT_NS      = 8_000_000;
   localparam logic [HEADING_WIDTH-1:0] LAST_HEADING = 17'd92159;
   localparam logic [HEADING_WIDTH-1:0] TOP_TARGET   = 17'h1FFFF;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [HEADING_WIDTH-1:0]   req_target_heading;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [HEADING_WIDTH-1:0]   rsp_smoothed_heading;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   int                         error_count;
   int                         pending_count;
   logic [HEADING_WIDTH-1:0]   needle_heading;

   // Idling on both channels, and a request for one long receiver hold-off
   bit                         idle_on;
   bit                         hold_off;
   logic [HEADING_WIDTH-1:0]   target_list[$];

   spring_damper_heading_smoother dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_target_heading   (req_target_heading),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_smoothed_heading (rsp_smoothed_heading),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   sdhs_checker heading_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_target_heading   (req_target_heading),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_smoothed_heading (rsp_smoothed_heading),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .error_count          (error_count),
      .pending_count        (pending_count),
      .needle_heading       (needle_heading)
   );

   // Clock generation
   always begin
      #CLOCK_LOW_NS clock = 1'b1;
      #CLOCK_HIGH_NS clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #RUN_LIMIT_NS;
      $display("tb_spring_damper_heading_smoother: done, errors");
      $finish;
   end

   // Write one gain register at a falling edge; it takes effect at the next rising edge.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Wait until every response has come back, then let the block run out its latency.
   task automatic settle();
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Offer every queued target in turn, with random gaps while idling is on.
   task automatic send_targets();
      int unsigned gap;
      while (target_list.size() != 0) begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 3) == 0) begin
            gap       = $urandom_range(1, 11);
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid          = 1'b1;
         req_target_heading = target_list.pop_front();
         do begin
            @(posedge clock);
         end while (req_ready !== 1'b1);
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // With the block drained the needle heading is known, so aim exactly half a turn away.
   task automatic send_half_turn();
      int pos;
      settle();
      pos = int'(needle_heading);
      if (pos < int'(HALF_TURN_S)) begin
         target_list.push_back(HEADING_WIDTH'(pos + int'(HALF_TURN_S)));
      end else begin
         target_list.push_back(HEADING_WIDTH'(pos - int'(HALF_TURN_S)));
      end
      send_targets();
   endtask

   // Mostly in-range headings, with range ends and out-of-range targets mixed in.
   function automatic logic [HEADING_WIDTH-1:0] random_target();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return LAST_HEADING;
         2:       return TOP_TARGET;
         3, 4:    return HEADING_WIDTH'($urandom_range(int'(FULL_TURN), int'(TOP_TARGET)));
         default: return HEADING_WIDTH'($urandom_range(0, int'(LAST_HEADING)));
      endcase
   endfunction

   // Receiver: random stalls, and one long hold-off on request
   initial begin
      int unsigned hold_count;
      int unsigned stall;
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready = 1'b0;
            for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++) begin
               @(negedge clock);
            end
            hold_off  = 1'b0;
            rsp_ready = 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall     = $urandom_range(1, 11);
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
            rsp_ready = 1'b1;
         end
      end
   end

   // Main sequence: reset, directed ticks, then random phases under several gain settings.
   initial begin
      int unsigned phase;
      int unsigned chunk;
      int unsigned drain_wait;
      logic [CSR_DATA_WIDTH-1:0] spring_setting;
      logic [CSR_DATA_WIDTH-1:0] damping_setting;
      logic [CSR_DATA_WIDTH-1:0] step_setting;

      reset              = 1'b1;
      req_valid          = 1'b0;
      req_target_heading = '0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_SPRING_PER_MASS;
      csr_write_data     = '0;
      idle_on            = 1'b1;
      hold_off           = 1'b0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Reset gains: range ends and targets that must be wrapped first
      target_list = '{17'd0, LAST_HEADING, TOP_TARGET, FULL_TURN, 17'd1};
      send_targets();
      send_half_turn();

      // Zero time step: the needle must not move at all
      settle();
      write_csr(CSR_TIME_STEP, '0);
      send_half_turn();
      target_list = '{TOP_TARGET, 17'd0, 17'd46081};
      send_targets();

      // Stiffest spring, no damping, longest step: velocity runs into saturation
      settle();
      write_csr(CSR_SPRING_PER_MASS, '1);
      write_csr(CSR_DAMPING_PER_MASS, '0);
      write_csr(CSR_TIME_STEP, '1);
      target_list = '{LAST_HEADING, 17'd0, 17'd46080, TOP_TARGET, 17'd65536, 17'd12345};
      send_targets();

      // Pure damping at full strength; a write to the unused index must change nothing
      settle();
      write_csr(CSR_SPRING_PER_MASS, '0);
      write_csr(CSR_DAMPING_PER_MASS, '1);
      write_csr(CSR_UNUSED_INDEX, '1);
      target_list = '{17'd0, LAST_HEADING, 17'd23040, 17'd69120};
      send_targets();

      // Random phases; the last one runs without any idling
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            1: begin
               spring_setting  = CSR_DATA_WIDTH'($urandom);
               damping_setting = CSR_DATA_WIDTH'($urandom);
               step_setting    = CSR_DATA_WIDTH'($urandom_range(1, 65535));
            end
            2: begin
               spring_setting  = '1;
               damping_setting = '1;
               step_setting    = '1;
            end
            3: begin
               spring_setting  = '0;
               damping_setting = '0;
               step_setting    = 16'd1;
            end
            4: begin
               spring_setting  = CSR_DATA_WIDTH'($urandom);
               damping_setting = CSR_DATA_WIDTH'($urandom);
               step_setting    = CSR_DATA_WIDTH'($urandom_range(1, 4096));
            end
            default: begin
               spring_setting  = SPRING_RESET;
               damping_setting = DAMPING_RESET;
               step_setting    = STEP_RESET;
            end
         endcase
         settle();
         write_csr(CSR_SPRING_PER_MASS, spring_setting);
         write_csr(CSR_DAMPING_PER_MASS, damping_setting);
         write_csr(CSR_TIME_STEP, step_setting);
         if (phase == 3) begin
            write_csr(CSR_UNUSED_INDEX, CSR_DATA_WIDTH'($urandom));
         end
         idle_on = (phase != PHASE_COUNT - 1);

         for (chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++) begin
            send_half_turn();
            repeat (ITEMS_PER_CHUNK - 1) target_list.push_back(random_target());
            // One long receiver hold-off while requests keep coming, so the block backs up
            if (phase == 1 && chunk == 1) begin
               hold_off = 1'b1;
            end
            send_targets();
         end
      end

      // Drain the last responses, then give the verdict
      drain_wait = 0;
      while (pending_count != 0 && drain_wait < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_spring_damper_heading_smoother: done, clean");
      end else begin
         $display("tb_spring_damper_heading_smoother: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
